>>> src/lsc_pkg.sv
package lsc_pkg;

    localparam int unsigned IDX_W   = 6;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned ISUM_W  = 9;

    localparam logic [DRIVE_W-1:0] MAX_INT_RST = 8'd204;
    localparam logic [DRIVE_W-1:0] INT_SCALE   = 8'd14;
    localparam logic [NIB_W-1:0]   NIB_MAX     = 4'hF;

    typedef enum logic {
        OP_PLAIN = 1'b0,
        OP_MERGE = 1'b1
    } t_op;

endpackage

>>> src/lsc_in_if.sv
interface lsc_in_if;
    import lsc_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [IDX_W-1:0]    light_index;
    logic [WORD_W-1:0]   color_a;
    logic [WORD_W-1:0]   color_b;

    modport source (output valid, output operation, output light_index,
                    output color_a, output color_b, input ready);
    modport sink   (input valid, input operation, input light_index,
                    input color_a, input color_b, output ready);
endinterface

>>> src/lsc_out_if.sv
interface lsc_out_if;
    import lsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    light_index_res;
    logic [DRIVE_W-1:0]  drive_intensity;
    logic [NIB_W-1:0]    red;
    logic [NIB_W-1:0]    green;
    logic [NIB_W-1:0]    blue;

    modport source (output valid, output light_index_res, output drive_intensity,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input light_index_res, input drive_intensity,
                    input red, input green, input blue, output ready);
endinterface

>>> src/lsc_cfg_if.sv
interface lsc_cfg_if;
    import lsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DRIVE_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/led_shadow_color_updater.sv
// Shadowed color updater for a string of lights. Each input transfer names a light and a
// color word (plain mode) or two words merged channel by channel with saturation. The block
// keeps a shadow copy of the last word per light and emits a drive command only when the new
// word differs from it. One transfer is taken every cycle unless the pipeline stalls; each
// passes in turn through the shadow memory read stage, the intensity scaling stage and the
// clamp and compare stage. Output back-pressure stalls the pipeline stage by stage, and empty
// stages still take new transfers. The shadow memory needs no clearing pass after reset: one
// valid flag per light marks entries written since reset, and others read as zero.
module led_shadow_color_updater #(
    parameter int unsigned LIGHTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsc_cfg_if.sink   i_cfg,
    lsc_in_if.sink    i_in,
    lsc_out_if.source o_res
);
    import lsc_pkg::*;

    localparam int unsigned DEPTH = (LIGHTS < (1 << IDX_W)) ? LIGHTS : (1 << IDX_W);
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DRIVE_W-1:0] r_max;

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [DEPTH-1:0]   r_mem_vld;

    // Stage A: shadow read.
    logic               r_va;
    logic               r_op_a;
    logic [IDX_W-1:0]   r_idx_a;
    logic [WORD_W-1:0]  r_a_a;
    logic [WORD_W-1:0]  r_b_a;
    logic [WORD_W-1:0]  r_rd_a;
    logic               r_rdv_a;
    logic               r_hit_a;
    logic [WORD_W-1:0]  r_fwd_a;

    // Stage B: scaled intensity and merged channels.
    logic               r_vb;
    logic               r_op_b;
    logic [IDX_W-1:0]   r_idx_b;
    logic [NIB_W-1:0]   r_ia_b;
    logic [ISUM_W-1:0]  r_isum_b;
    logic [NIB_W-1:0]   r_r_b;
    logic [NIB_W-1:0]   r_g_b;
    logic [NIB_W-1:0]   r_bl_b;
    logic [WORD_W-1:0]  r_sh_b;

    // Output register.
    logic               r_vo;
    logic [IDX_W-1:0]   r_idx_o;
    logic [DRIVE_W-1:0] r_drv_o;
    logic [NIB_W-1:0]   r_r_o;
    logic [NIB_W-1:0]   r_g_o;
    logic [NIB_W-1:0]   r_bl_o;

    logic               rdy_o;
    logic               rdy_b;
    logic               rdy_a;
    logic               in_xfer;
    logic               in_range;
    logic [AW-1:0]      in_addr;

    logic [WORD_W-1:0]  sh_a;
    logic [ISUM_W-1:0]  n_isum;
    logic [NIB_W-1:0]   n_r;
    logic [NIB_W-1:0]   n_g;
    logic [NIB_W-1:0]   n_bl;
    logic [DRIVE_W-1:0] sc_a;
    logic [DRIVE_W-1:0] sc_b;
    logic [NIB_W:0]     sum_r;
    logic [NIB_W:0]     sum_g;
    logic [NIB_W:0]     sum_bl;

    logic [DRIVE_W-1:0] drv_b;
    logic [WORD_W-1:0]  word_b;
    logic               diff_b;
    logic               we;
    logic [AW-1:0]      wr_addr;

    assign rdy_o    = !r_vo || o_res.ready;
    assign rdy_b    = !r_vb || rdy_o;
    assign rdy_a    = !r_va || rdy_b;
    assign in_xfer  = i_in.valid && rdy_a;
    assign in_range = ({{(32-IDX_W){1'b0}}, i_in.light_index} < 32'(LIGHTS));
    assign in_addr  = i_in.light_index[AW-1:0];

    assign i_in.ready  = rdy_a;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_INT_RST;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.data;
        end
    end

    // Stage B combinational: clamp, candidate word and compare.
    always_comb begin
        drv_b   = (r_isum_b > {1'b0, r_max}) ? r_max : r_isum_b[DRIVE_W-1:0];
        word_b  = (t_op'(r_op_b) == OP_MERGE) ? {drv_b[NIB_W-1:0], r_r_b, r_g_b, r_bl_b}
                                              : {r_ia_b, r_r_b, r_g_b, r_bl_b};
        diff_b  = (word_b != r_sh_b);
        we      = r_vb && rdy_o && diff_b;
        wr_addr = r_idx_b[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_a <= r_mem[in_addr];
        end
        if (we) begin
            r_mem[wr_addr] <= word_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (we) begin
            r_mem_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (rdy_a) begin
            r_va <= i_in.valid && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op_a  <= i_in.operation;
            r_idx_a <= i_in.light_index;
            r_a_a   <= i_in.color_a;
            r_b_a   <= i_in.color_b;
            r_rdv_a <= r_mem_vld[in_addr];
            r_hit_a <= we && (wr_addr == in_addr);
            r_fwd_a <= word_b;
        end else if (we && (wr_addr == r_idx_a[AW-1:0])) begin
            r_hit_a <= 1'b1;
            r_fwd_a <= word_b;
        end
    end

    // Stage A combinational: current shadow word, scaled intensity, channel merge.
    always_comb begin
        sh_a   = r_hit_a ? r_fwd_a : (r_rdv_a ? r_rd_a : '0);
        sc_a   = {{(DRIVE_W-NIB_W){1'b0}}, r_a_a[15:12]} * INT_SCALE;
        sc_b   = {{(DRIVE_W-NIB_W){1'b0}}, r_b_a[15:12]} * INT_SCALE;
        sum_r  = {1'b0, r_a_a[11:8]} + {1'b0, r_b_a[11:8]};
        sum_g  = {1'b0, r_a_a[7:4]} + {1'b0, r_b_a[7:4]};
        sum_bl = {1'b0, r_a_a[3:0]} + {1'b0, r_b_a[3:0]};
        if (t_op'(r_op_a) == OP_MERGE) begin
            n_isum = {1'b0, sc_a} + {1'b0, sc_b};
            n_r    = sum_r[NIB_W]  ? NIB_MAX : sum_r[NIB_W-1:0];
            n_g    = sum_g[NIB_W]  ? NIB_MAX : sum_g[NIB_W-1:0];
            n_bl   = sum_bl[NIB_W] ? NIB_MAX : sum_bl[NIB_W-1:0];
        end else begin
            n_isum = {1'b0, sc_a};
            n_r    = r_a_a[11:8];
            n_g    = r_a_a[7:4];
            n_bl   = r_a_a[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_op_b   <= r_op_a;
            r_idx_b  <= r_idx_a;
            r_ia_b   <= r_a_a[15:12];
            r_isum_b <= n_isum;
            r_r_b    <= n_r;
            r_g_b    <= n_g;
            r_bl_b   <= n_bl;
            r_sh_b   <= (we && (wr_addr == r_idx_a[AW-1:0])) ? word_b : sh_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdy_o) begin
            r_vo <= r_vb && diff_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_idx_o <= r_idx_b;
            r_drv_o <= drv_b;
            r_r_o   <= r_r_b;
            r_g_o   <= r_g_b;
            r_bl_o  <= r_bl_b;
        end
    end

    assign o_res.valid           = r_vo;
    assign o_res.light_index_res = r_idx_o;
    assign o_res.drive_intensity = r_drv_o;
    assign o_res.red             = r_r_o;
    assign o_res.green           = r_g_o;
    assign o_res.blue            = r_bl_o;

    a_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_vo)
        else $error("shadow write without a result");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_va && !r_vb && !r_vo))
        else $error("pipeline not empty after reset");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ({{(32-IDX_W){1'b0}}, r_idx_o} < 32'(LIGHTS)))
        else $error("result for a light beyond the string");

    a_unchanged_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && rdy_o && !diff_b) |=> !r_vo)
        else $error("result for an unchanged word");

endmodule
